@@ rtl/dro_pkg.sv @@
// shared types, constants and angle table for the dead reckoning odometry block
package dro_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_BITS   = 32;
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    // keeps only the top ANGLE_BITS bits of a binary angle
    localparam logic [31:0] ANGLE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [15:0] Q14_ONE     = 16'sd16384;

    // position divisor 16384000000 = 2^20 * 15625
    localparam int          QUOT_BITS = 17;
    localparam logic [21:0] DIV_ODD   = 22'd15625;
    // floor(2^35 / 15625), low by at most one in the quotient for a 30-bit dividend
    localparam logic [21:0] DIV_RECIP = 22'd2199023;
    localparam logic [50:0] POS_HALF  = 51'd8192000000;

    localparam logic [21:0] YAW_MUL  = 22'd2799883;
    localparam logic [57:0] YAW_HALF = 58'd8388608;

    typedef struct packed {
        logic signed [15:0] speed;
        logic signed [15:0] yaw_rate;
        logic [19:0]        elapsed_us;
        logic               reset_pose;
    } tick_t;

    typedef struct packed {
        logic signed [39:0] pos_x;
        logic signed [39:0] pos_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] speed_out;
    } pose_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T1_GO,
        S_T1_WAIT,
        S_MUL_A,
        S_MUL_B,
        S_DIV_SET,
        S_DIV,
        S_QUOT,
        S_FIX,
        S_ACC,
        S_YAW1,
        S_YAW2,
        S_YAW3,
        S_YAW4,
        S_HEAD,
        S_T2_GO,
        S_T2_WAIT,
        S_DONE
    } dro_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_ITER,
        C_ROUND
    } cordic_state_t;

    // atan(2^-i) in binary angle units, 2^32 = full turn
    function automatic logic [31:0] atan_entry(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            5'd24:   v = 32'd41;
            5'd25:   v = 32'd20;
            5'd26:   v = 32'd10;
            5'd27:   v = 32'd5;
            5'd28:   v = 32'd3;
            5'd29:   v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/dead_reckoning_odometry_top.sv @@
// dead reckoning odometry: sequencer, shared multiplier and pose state
//
// Each accepted tick integrates speed along the current heading into x and y
// (1/256 m, saturating at 40 bits), then advances the 32-bit wrapping heading
// by yaw_rate * elapsed_us, and returns one pose holding the position, the yaw
// quaternion of the new heading and the speed. A tick with reset_pose set
// zeroes the pose. Any other tick runs two passes of the iterative cordic
// plus, per axis, two products, a reciprocal multiplication and one
// compare-and-subtract correction for the position increment, all sharing one
// 32x22 multiplier. tick_ready is high only between ticks; a finished pose
// waits in its output register without holding up the next tick, but a tick
// only finishes once the pose before it has been taken.
module dead_reckoning_odometry_top
    import dro_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  tick_valid,
    output logic  tick_ready,
    input  tick_t tick,
    output logic  pose_valid,
    input  logic  pose_ready,
    output pose_t pose
);

    dro_state_t         state_reg, state_next;
    logic               pose_valid_reg, pose_valid_next;
    pose_t              pose_reg, pose_next;
    logic               axis_reg, axis_next;

    logic signed [39:0] east_reg, east_next;
    logic signed [39:0] north_reg, north_next;
    logic [31:0]        heading_reg, heading_next;

    logic signed [15:0] spd_reg, spd_next;
    logic signed [15:0] yaw_reg, yaw_next;
    logic [19:0]        dt_reg, dt_next;
    logic signed [15:0] cos_reg, cos_next;
    logic signed [15:0] sin_reg, sin_next;
    logic signed [15:0] qz_reg, qz_next;
    logic signed [15:0] qw_reg, qw_next;
    logic [53:0]        prod_reg, prod_next;
    logic [17:0]        mhi_reg, mhi_next;
    logic [57:0]        acc_reg, acc_next;
    logic [29:0]        rem_reg, rem_next;
    logic [QUOT_BITS-1:0] quot_reg, quot_next;
    logic               neg_reg, neg_next;

    logic [31:0]        mul_a;
    logic [21:0]        mul_b;
    logic [53:0]        mul_p;

    logic               cordic_start;
    logic [31:0]        cordic_angle;
    logic               cordic_done;
    logic signed [15:0] cordic_cos;
    logic signed [15:0] cordic_sin;

    logic signed [15:0] trig_sel;
    logic [14:0]        trig_mag;
    logic [15:0]        spd_mag;
    logic [15:0]        yaw_mag;
    logic [50:0]        pos_num;
    logic [29:0]        div_rem;
    logic signed [17:0] pos_step;
    logic signed [39:0] pos_old;
    logic signed [40:0] pos_sum;
    logic signed [39:0] pos_sat;
    logic [31:0]        dh;

    dro_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (cordic_angle),
        .done  (cordic_done),
        .cos_q (cordic_cos),
        .sin_q (cordic_sin)
    );

    // the one multiplier every product goes through
    assign mul_p = 54'(mul_a) * 54'(mul_b);

    assign trig_sel = axis_reg ? sin_reg : cos_reg;
    assign trig_mag = trig_sel[15] ? 15'(-trig_sel) : 15'(trig_sel);
    assign spd_mag  = spd_reg[15] ? 16'(-spd_reg) : 16'(spd_reg);
    assign yaw_mag  = yaw_reg[15] ? 16'(-yaw_reg) : 16'(yaw_reg);

    assign pos_num  = prod_reg[50:0] + POS_HALF;
    assign div_rem  = rem_reg - prod_reg[29:0];
    assign pos_step = neg_reg ? -$signed({1'b0, quot_reg}) : $signed({1'b0, quot_reg});
    assign pos_old  = axis_reg ? north_reg : east_reg;
    assign pos_sum  = {pos_old[39], pos_old} + {{23{pos_step[17]}}, pos_step};
    assign pos_sat  = (pos_sum[40] == pos_sum[39]) ? pos_sum[39:0] :
                      (pos_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}});
    assign dh       = acc_reg[55:24];

    assign tick_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        pose_valid_next = pose_valid_reg && !pose_ready;
        pose_next       = pose_reg;
        axis_next       = axis_reg;
        east_next       = east_reg;
        north_next      = north_reg;
        heading_next    = heading_reg;
        spd_next        = spd_reg;
        yaw_next        = yaw_reg;
        dt_next         = dt_reg;
        cos_next        = cos_reg;
        sin_next        = sin_reg;
        qz_next         = qz_reg;
        qw_next         = qw_reg;
        prod_next       = prod_reg;
        mhi_next        = mhi_reg;
        acc_next        = acc_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        neg_next        = neg_reg;
        mul_a           = 32'd0;
        mul_b           = 22'd0;
        cordic_start    = 1'b0;
        cordic_angle    = heading_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_valid)
                begin
                    spd_next = tick.speed;
                    yaw_next = tick.yaw_rate;
                    dt_next  = tick.elapsed_us;
                    if (tick.reset_pose)
                    begin
                        east_next    = 40'sd0;
                        north_next   = 40'sd0;
                        heading_next = 32'd0;
                        qz_next      = 16'sd0;
                        qw_next      = Q14_ONE;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        state_next = S_T1_GO;
                    end
                end
            end
            S_T1_GO:
            begin
                cordic_start = 1'b1;
                state_next   = S_T1_WAIT;
            end
            S_T1_WAIT:
            begin
                if (cordic_done)
                begin
                    cos_next   = cordic_cos;
                    sin_next   = cordic_sin;
                    axis_next  = 1'b0;
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A:
            begin
                mul_a      = 32'(spd_mag);
                mul_b      = 22'(trig_mag);
                prod_next  = mul_p;
                neg_next   = spd_reg[15] ^ trig_sel[15];
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                mul_a      = 32'(prod_reg[29:0]);
                mul_b      = 22'(dt_reg);
                prod_next  = mul_p;
                state_next = S_DIV_SET;
            end
            S_DIV_SET:
            begin
                // the 2^20 factor of the divisor is a shift by 20 bits
                rem_next   = pos_num[49:20];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                mul_a      = 32'(rem_reg);
                mul_b      = DIV_RECIP;
                prod_next  = mul_p;
                state_next = S_QUOT;
            end
            S_QUOT:
            begin
                // estimate is the true quotient or one below it
                quot_next  = prod_reg[51:35];
                mul_a      = 32'(prod_reg[51:35]);
                mul_b      = DIV_ODD;
                prod_next  = mul_p;
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (div_rem >= {8'd0, DIV_ODD})
                begin
                    quot_next = quot_reg + 1'b1;
                end
                state_next = S_ACC;
            end
            S_ACC:
            begin
                if (axis_reg)
                begin
                    north_next = pos_sat;
                    state_next = S_YAW1;
                end
                else
                begin
                    east_next  = pos_sat;
                    axis_next  = 1'b1;
                    state_next = S_MUL_A;
                end
            end
            S_YAW1:
            begin
                mul_a      = 32'(yaw_mag);
                mul_b      = 22'(dt_reg);
                prod_next  = mul_p;
                neg_next   = yaw_reg[15];
                state_next = S_YAW2;
            end
            S_YAW2:
            begin
                mul_a      = 32'(prod_reg[17:0]);
                mul_b      = YAW_MUL;
                prod_next  = mul_p;
                mhi_next   = prod_reg[35:18];
                state_next = S_YAW3;
            end
            S_YAW3:
            begin
                acc_next   = {4'd0, prod_reg} + YAW_HALF;
                mul_a      = 32'(mhi_reg);
                mul_b      = YAW_MUL;
                prod_next  = mul_p;
                state_next = S_YAW4;
            end
            S_YAW4:
            begin
                acc_next   = acc_reg + {prod_reg[39:0], 18'd0};
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                // heading wraps, so only the low 32 bits of the step matter
                heading_next = neg_reg ? heading_reg - dh : heading_reg + dh;
                state_next   = S_T2_GO;
            end
            S_T2_GO:
            begin
                cordic_start = 1'b1;
                cordic_angle = {heading_reg[31], heading_reg[31:1]};
                state_next   = S_T2_WAIT;
            end
            S_T2_WAIT:
            begin
                if (cordic_done)
                begin
                    qw_next    = cordic_cos;
                    qz_next    = cordic_sin;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!pose_valid_reg || pose_ready)
                begin
                    pose_next.pos_x     = east_reg;
                    pose_next.pos_y     = north_reg;
                    pose_next.quat_z    = qz_reg;
                    pose_next.quat_w    = qw_reg;
                    pose_next.speed_out = spd_reg;
                    pose_valid_next     = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pose_valid_reg <= 1'b0;
            axis_reg       <= 1'b0;
            east_reg       <= 40'sd0;
            north_reg      <= 40'sd0;
            heading_reg    <= 32'd0;
        end
        else
        begin
            state_reg      <= state_next;
            pose_valid_reg <= pose_valid_next;
            axis_reg       <= axis_next;
            east_reg       <= east_next;
            north_reg      <= north_next;
            heading_reg    <= heading_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pose_reg <= pose_next;
        spd_reg  <= spd_next;
        yaw_reg  <= yaw_next;
        dt_reg   <= dt_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
        qz_reg   <= qz_next;
        qw_reg   <= qw_next;
        prod_reg <= prod_next;
        mhi_reg  <= mhi_next;
        acc_reg  <= acc_next;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        neg_reg  <= neg_next;
    end

    assign pose_valid = pose_valid_reg;
    assign pose       = pose_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready && tick.reset_pose |=>
            (east_reg == 40'sd0) && (north_reg == 40'sd0) && (heading_reg == 32'd0))
        else $error("reset request did not clear the pose");

    // half heading lies in [-pi/2, pi/2), so w can never go negative
    assert property (@(posedge clk) disable iff (!rst_n)
        pose_valid_reg |-> !pose_reg.quat_w[15])
        else $error("negative quaternion w");

    assert property (@(posedge clk) disable iff (!rst_n)
        cordic_done |-> (state_reg == S_T1_WAIT) || (state_reg == S_T2_WAIT))
        else $error("cordic finished while sequencer not waiting");
`endif

endmodule

@@ rtl/dro_cordic.sv @@
// iterative rotation-mode cordic giving cosine and sine of a binary angle in Q1.14
module dro_cordic
    import dro_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [31:0]        angle,
    output logic               done,
    output logic signed [15:0] cos_q,
    output logic signed [15:0] sin_q
);

    cordic_state_t      state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               done_reg, done_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic               flip_reg, flip_next;
    logic signed [15:0] cos_reg, cos_next;
    logic signed [15:0] sin_reg, sin_next;

    logic [31:0]        a_masked;
    logic               fold;
    logic signed [31:0] dx, dy;
    logic [31:0]        atan_val;

    // Q2.30 to Q1.14, round half away from zero, clamp, then undo the fold
    function automatic logic signed [15:0] round_q14(input logic signed [31:0] v,
                                                     input logic flip);
        logic [31:0] mag;
        logic [16:0] q;
        logic [15:0] r;
        mag = v[31] ? 32'(-v) : 32'(v);
        q   = 17'((mag + 32'd32768) >> 16);
        if (q > 17'd16384)
        begin
            q = 17'd16384;
        end
        r = q[15:0];
        if (v[31] ^ flip)
        begin
            r = -r;
        end
        return r;
    endfunction

    assign a_masked = angle & ANGLE_MASK;
    // outside [-pi/2, pi/2]: rotate by pi, which is flipping the top bit
    assign fold = (!a_masked[31] && a_masked[30] && (a_masked[29:0] != 30'd0)) ||
                  (a_masked[31] && !a_masked[30]);
    assign dx       = y_reg >>> step_reg;
    assign dy       = x_reg >>> step_reg;
    assign atan_val = atan_entry(5'(step_reg));

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    x_next     = CORDIC_GAIN;
                    y_next     = 32'sd0;
                    z_next     = fold ? {~a_masked[31], a_masked[30:0]} : a_masked;
                    flip_next  = fold;
                    step_next  = '0;
                    state_next = C_ITER;
                end
            end
            C_ITER:
            begin
                if (!z_reg[31])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - $signed(atan_val);
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + $signed(atan_val);
                end
                if (step_reg == STEP_W'(CORDIC_STEPS - 1))
                begin
                    state_next = C_ROUND;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            C_ROUND:
            begin
                cos_next   = round_q14(x_reg, flip_reg);
                sin_next   = round_q14(y_reg, flip_reg);
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        flip_reg <= flip_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign done  = done_reg;
    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

`ifndef SYNTH
    // the sequencer never restarts the unit mid-rotation
    assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == C_IDLE)
        else $error("cordic started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (cos_reg <= 16'sd16384) && (cos_reg >= -16'sd16384) &&
                     (sin_reg <= 16'sd16384) && (sin_reg >= -16'sd16384))
        else $error("cordic result outside unit range");
`endif

endmodule
